// ===== sv/fcp_pkg.sv =====
package fcp_pkg;

  localparam int MulW = 34;
  localparam int ProdW = 2 * MulW;

  localparam int Deg90 = 11520;
  localparam int Deg180 = 23040;
  localparam int Deg360 = 46080;
  localparam int PitchLimit = 11392;
  localparam int Unit = 16384;
  localparam int PosMax = 8388607;
  localparam int PosMin = -8388608;
  localparam int YawBias = 5760;

  localparam logic [MulW-1:0] RadPerDeg = 34'd74961321;
  localparam logic [13:0] ModStep = 14'd45;

  localparam logic [15:0] SpeedReset = 16'd640;
  localparam logic [15:0] SensReset = 16'd6554;

  localparam logic [1:0] RegSpeed = 2'd0;
  localparam logic [1:0] RegSens = 2'd1;
  localparam logic [1:0] RegUnused = 2'd3;

  // series divisors 72, 42, 20, 6 and floor(2^32 / d)
  localparam logic [MulW-1:0] DivD [4] = '{34'd72, 34'd42, 34'd20, 34'd6};
  localparam logic [MulW-1:0] DivM [4] =
    '{34'd59652323, 34'd102261126, 34'd214748364, 34'd715827882};

  typedef enum logic [4:0] {
    ST_IDLE, ST_MV_VEL, ST_MV_VELW, ST_MV_KEY, ST_MV_MUL, ST_MV_ADD,
    ST_LK_DX, ST_LK_DY, ST_LK_ANG, ST_LK_MOD, ST_LK_YAW,
    ST_SN_RED, ST_SN_X, ST_SN_XS, ST_SN_SQ, ST_SN_SQS,
    ST_DV_RCP, ST_DV_Q, ST_DV_CHK, ST_DV_FIX, ST_DV_TN, ST_DV_TNS,
    ST_SN_S, ST_SN_SS, ST_VC_MUL, ST_VC_ST, ST_DONE
  } state_t;

endpackage

// ===== sv/fcp_mul.sv =====
module fcp_mul (
  input  logic                                clk,
  input  logic signed [fcp_pkg::MulW-1:0]     a,
  input  logic signed [fcp_pkg::MulW-1:0]     b,
  output logic signed [fcp_pkg::ProdW-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== sv/fly_camera_pose_update.sv =====
// Channel   | Dir | Payload
// s_*       | in  | tuser: operation; tdata: key_mask, delta_time, x_offset, y_offset
// m_*       | out | tdata: pos xyz, front xyz, right xyz, up xyz
// cfg_*     | in  | index 0 movement_speed, 1 mouse_sensitivity
// One request at a time through a single shared 34x34 multiplier and a sequencer.
// Move: a speed by delta_time product, then a multiply-add on each axis per pressed key.
// Look: four sine evaluations on the shared multiplier.
// The result waits in an output register; a new request is taken meanwhile.
// rst is synchronous and restores the initial pose and register values.
module fly_camera_pose_update (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic         s_tuser,   // operation
  input  logic [55:0]  s_tdata,   // key_mask, delta_time, x_offset, y_offset, zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [215:0] m_tdata,   // pos_x,y,z, front_x,y,z, right_x,y,z, up_x,y,z
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int MW = fcp_pkg::MulW;
  localparam int PW = fcp_pkg::ProdW;

  fcp_pkg::state_t state, state_next;

  logic [15:0] speed, sens;
  logic [5:0] keys;
  logic [15:0] dt;
  logic signed [15:0] xo, yo;
  logic [31:0] vel;
  logic [2:0] k;
  logic [1:0] i, dv, j, vi;
  logic [2:0] cnt;
  logic signed [23:0] pos [3];
  logic signed [15:0] yaw;
  logic signed [14:0] pitch;
  logic signed [15:0] front [3];
  logic signed [15:0] right [3];
  logic signed [15:0] up [3];
  logic signed [15:0] sv [4];
  logic signed [23:0] dx;
  logic [13:0] u;
  logic [9:0] low10;
  logic [13:0] r;
  logic neg;
  logic [30:0] x, t;
  logic [31:0] x2, n, qe;

  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic out_load;

  fcp_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(prod));

  // move datapath
  logic signed [15:0] mv_vec;
  logic mv_neg;
  logic signed [PW-1:0] mv_sum;
  logic signed [18:0] mv_d;
  logic signed [25:0] mv_p;
  logic signed [23:0] mv_sat;

  always_comb begin
    case (k[2:1])
      2'd0: mv_vec = front[i];
      2'd1: mv_vec = right[i];
      default: mv_vec = up[i];
    endcase
    mv_neg = k inside {3'd1, 3'd2, 3'd5};
    mv_sum = prod + PW'(64'sd536870912);
    mv_d = mv_sum[48:30];
    mv_p = mv_neg ? (26'(pos[i]) - 26'(mv_d)) : (26'(pos[i]) + 26'(mv_d));
    if (mv_p > 26'(fcp_pkg::PosMax)) mv_sat = 24'(fcp_pkg::PosMax);
    else if (mv_p < 26'(fcp_pkg::PosMin)) mv_sat = 24'(fcp_pkg::PosMin);
    else mv_sat = mv_p[23:0];
  end

  // look datapath
  logic signed [PW-1:0] lk_sum;
  logic signed [23:0] lk_d;
  logic signed [24:0] lk_y, lk_p;
  logic signed [14:0] lk_pc;
  logic [13:0] mod_sub;

  always_comb begin
    lk_sum = prod + PW'(256);
    lk_d = lk_sum[32:9];
    lk_y = 25'(yaw) + 25'(dx) + 25'(fcp_pkg::Deg180);
    lk_p = 25'(pitch) + 25'(lk_d);
    if (lk_p > 25'(fcp_pkg::PitchLimit)) lk_pc = 15'(fcp_pkg::PitchLimit);
    else if (lk_p < -25'(fcp_pkg::PitchLimit)) lk_pc = -15'(fcp_pkg::PitchLimit);
    else lk_pc = lk_p[14:0];
    mod_sub = fcp_pkg::ModStep << cnt;
  end

  // sine reduction, quotient correction and result rounding
  logic signed [16:0] sn_a;
  logic [15:0] sn_m;
  logic [1:0] sn_q;
  logic [15:0] sn_r;
  logic [63:0] dv_q;
  logic [16:0] sn_s2;
  logic [15:0] sn_cap;

  always_comb begin
    case (j)
      2'd0: sn_a = 17'(yaw);
      2'd1: sn_a = 17'(yaw) + 17'(fcp_pkg::Deg90);
      2'd2: sn_a = 17'(pitch);
      default: sn_a = 17'(pitch) + 17'(fcp_pkg::Deg90);
    endcase
    sn_m = sn_a[16] ? 16'(sn_a + 17'(fcp_pkg::Deg360)) : sn_a[15:0];
    if (sn_m >= 16'(3 * fcp_pkg::Deg90)) sn_q = 2'd3;
    else if (sn_m >= 16'(fcp_pkg::Deg180)) sn_q = 2'd2;
    else if (sn_m >= 16'(fcp_pkg::Deg90)) sn_q = 2'd1;
    else sn_q = 2'd0;
    sn_r = sn_m - 16'(sn_q) * 16'(fcp_pkg::Deg90);
    if (sn_q[0]) sn_r = 16'(fcp_pkg::Deg90) - sn_r;
    dv_q = ({32'd0, n} >= 64'(prod)) ? 64'(qe) + 64'd1 : 64'(qe);
    sn_s2 = 17'((prod[61:30] + 32'd32768) >> 16);
    sn_cap = (sn_s2 > 17'(fcp_pkg::Unit)) ? 16'(fcp_pkg::Unit) : sn_s2[15:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fcp_pkg::ST_IDLE:
        if (s_tvalid) state_next = s_tuser ? fcp_pkg::ST_LK_DX : fcp_pkg::ST_MV_VEL;
      fcp_pkg::ST_MV_VEL: state_next = fcp_pkg::ST_MV_VELW;
      fcp_pkg::ST_MV_VELW: state_next = fcp_pkg::ST_MV_KEY;
      fcp_pkg::ST_MV_KEY: begin
        if (k == 3'd6) state_next = fcp_pkg::ST_DONE;
        else if (keys[k]) state_next = fcp_pkg::ST_MV_MUL;
      end
      fcp_pkg::ST_MV_MUL: state_next = fcp_pkg::ST_MV_ADD;
      fcp_pkg::ST_MV_ADD:
        state_next = (i == 2'd2) ? fcp_pkg::ST_MV_KEY : fcp_pkg::ST_MV_MUL;
      fcp_pkg::ST_LK_DX: state_next = fcp_pkg::ST_LK_DY;
      fcp_pkg::ST_LK_DY: state_next = fcp_pkg::ST_LK_ANG;
      fcp_pkg::ST_LK_ANG: state_next = fcp_pkg::ST_LK_MOD;
      fcp_pkg::ST_LK_MOD: if (cnt == 3'd0) state_next = fcp_pkg::ST_LK_YAW;
      fcp_pkg::ST_LK_YAW: state_next = fcp_pkg::ST_SN_RED;
      fcp_pkg::ST_SN_RED: state_next = fcp_pkg::ST_SN_X;
      fcp_pkg::ST_SN_X: state_next = fcp_pkg::ST_SN_XS;
      fcp_pkg::ST_SN_XS: state_next = fcp_pkg::ST_SN_SQ;
      fcp_pkg::ST_SN_SQ: state_next = fcp_pkg::ST_SN_SQS;
      fcp_pkg::ST_SN_SQS: state_next = fcp_pkg::ST_DV_RCP;
      fcp_pkg::ST_DV_RCP: state_next = fcp_pkg::ST_DV_Q;
      fcp_pkg::ST_DV_Q: state_next = fcp_pkg::ST_DV_CHK;
      fcp_pkg::ST_DV_CHK: state_next = fcp_pkg::ST_DV_FIX;
      fcp_pkg::ST_DV_FIX:
        state_next = (dv == 2'd3) ? fcp_pkg::ST_SN_S : fcp_pkg::ST_DV_TN;
      fcp_pkg::ST_DV_TN: state_next = fcp_pkg::ST_DV_TNS;
      fcp_pkg::ST_DV_TNS: state_next = fcp_pkg::ST_DV_RCP;
      fcp_pkg::ST_SN_S: state_next = fcp_pkg::ST_SN_SS;
      fcp_pkg::ST_SN_SS:
        state_next = (j == 2'd3) ? fcp_pkg::ST_VC_MUL : fcp_pkg::ST_SN_RED;
      fcp_pkg::ST_VC_MUL: state_next = fcp_pkg::ST_VC_ST;
      fcp_pkg::ST_VC_ST:
        state_next = (vi == 2'd3) ? fcp_pkg::ST_DONE : fcp_pkg::ST_VC_MUL;
      fcp_pkg::ST_DONE: if (!m_tvalid || m_tready) state_next = fcp_pkg::ST_IDLE;
      default: state_next = fcp_pkg::ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    s_tready = (state == fcp_pkg::ST_IDLE);
    out_load = (state == fcp_pkg::ST_DONE) && (!m_tvalid || m_tready);
    ma = '0;
    mb = '0;
    case (state)
      fcp_pkg::ST_MV_VEL: begin
        ma = MW'(speed);
        mb = MW'(dt);
      end
      fcp_pkg::ST_MV_MUL: begin
        ma = MW'(mv_vec);
        mb = MW'(vel);
      end
      fcp_pkg::ST_LK_DX: begin
        ma = MW'(xo);
        mb = MW'(sens);
      end
      fcp_pkg::ST_LK_DY: begin
        ma = MW'(yo);
        mb = MW'(sens);
      end
      fcp_pkg::ST_SN_X: begin
        ma = MW'(r);
        mb = fcp_pkg::RadPerDeg;
      end
      fcp_pkg::ST_SN_SQ: begin
        ma = MW'(x);
        mb = MW'(x);
      end
      fcp_pkg::ST_DV_RCP: begin
        ma = MW'(n);
        mb = fcp_pkg::DivM[dv];
      end
      fcp_pkg::ST_DV_CHK: begin
        ma = MW'(33'(qe) + 33'd1);
        mb = fcp_pkg::DivD[dv];
      end
      fcp_pkg::ST_DV_TN: begin
        ma = MW'(x2);
        mb = MW'(t);
      end
      fcp_pkg::ST_SN_S: begin
        ma = MW'(x);
        mb = MW'(t);
      end
      fcp_pkg::ST_VC_MUL: begin
        case (vi)
          2'd0: begin ma = MW'(sv[1]);  mb = MW'(sv[3]); end
          2'd1: begin ma = MW'(sv[0]);  mb = MW'(sv[3]); end
          2'd2: begin ma = -MW'(sv[1]); mb = MW'(sv[2]); end
          default: begin ma = -MW'(sv[0]); mb = MW'(sv[2]); end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  function automatic logic signed [15:0] mv_vc_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + PW'(8192);
    return s[29:14];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcp_pkg::ST_IDLE;
      speed <= fcp_pkg::SpeedReset;
      sens <= fcp_pkg::SensReset;
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
      yaw <= -16'(fcp_pkg::Deg90);
      pitch <= '0;
      front[0] <= '0;
      front[1] <= '0;
      front[2] <= -16'(fcp_pkg::Unit);
      right[0] <= 16'(fcp_pkg::Unit);
      right[1] <= '0;
      right[2] <= '0;
      up[0] <= '0;
      up[1] <= 16'(fcp_pkg::Unit);
      up[2] <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == fcp_pkg::RegSpeed) speed <= cfg_data;
        else if (cfg_index == fcp_pkg::RegSens) sens <= cfg_data;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        fcp_pkg::ST_MV_ADD: pos[i] <= mv_sat;
        fcp_pkg::ST_LK_ANG: pitch <= lk_pc;
        fcp_pkg::ST_LK_YAW:
          yaw <= 16'({u[5:0], low10}) - 16'(fcp_pkg::Deg180);
        fcp_pkg::ST_SN_SS: sv[j] <= neg ? -16'(sn_cap) : 16'(sn_cap);
        fcp_pkg::ST_VC_ST: begin
          case (vi)
            2'd0: front[0] <= mv_vc_round(prod);
            2'd1: front[2] <= mv_vc_round(prod);
            2'd2: up[0] <= mv_vc_round(prod);
            default: begin
              up[2] <= mv_vc_round(prod);
              front[1] <= sv[2];
              right[0] <= -sv[0];
              right[1] <= '0;
              right[2] <= sv[1];
              up[1] <= sv[3];
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      fcp_pkg::ST_IDLE: begin
        keys <= s_tdata[5:0];
        dt <= s_tdata[21:6];
        xo <= s_tdata[37:22];
        yo <= s_tdata[53:38];
      end
      fcp_pkg::ST_MV_VELW: begin
        vel <= prod[31:0];
        k <= '0;
      end
      fcp_pkg::ST_MV_KEY: begin
        i <= '0;
        if (k != 3'd6 && !keys[k]) k <= k + 3'd1;
      end
      fcp_pkg::ST_MV_ADD: begin
        if (i == 2'd2) k <= k + 3'd1;
        else i <= i + 2'd1;
      end
      fcp_pkg::ST_LK_DY: dx <= lk_d;
      fcp_pkg::ST_LK_ANG: begin
        u <= 14'(lk_y[24:10] + 15'(fcp_pkg::YawBias));
        low10 <= lk_y[9:0];
        cnt <= 3'd7;
      end
      fcp_pkg::ST_LK_MOD: begin
        if (u >= mod_sub) u <= u - mod_sub;
        cnt <= cnt - 3'd1;
      end
      fcp_pkg::ST_LK_YAW: j <= '0;
      fcp_pkg::ST_SN_RED: begin
        r <= sn_r[13:0];
        neg <= sn_q[1];
      end
      fcp_pkg::ST_SN_XS: x <= prod[39:9];
      fcp_pkg::ST_SN_SQS: begin
        x2 <= prod[61:30];
        n <= prod[61:30];
        dv <= '0;
      end
      fcp_pkg::ST_DV_Q: qe <= prod[63:32];
      fcp_pkg::ST_DV_FIX: begin
        t <= 31'(32'h4000_0000 - dv_q[31:0]);
        if (dv != 2'd3) dv <= dv + 2'd1;
      end
      fcp_pkg::ST_DV_TNS: n <= prod[61:30];
      fcp_pkg::ST_SN_SS: begin
        j <= j + 2'd1;
        vi <= '0;
      end
      fcp_pkg::ST_VC_ST: vi <= vi + 2'd1;
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {up[2], up[1], up[0], right[2], right[1], right[0],
                  front[2], front[1], front[0], pos[2], pos[1], pos[0]};
    end
  end

endmodule

// ===== sv/fcp_checker.sv =====
module fcp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [215:0] m_tdata
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_right_y: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[151:136] == 16'd0)
    else $error("right vector has a y component");

endmodule

bind fly_camera_pose_update fcp_checker u_fcp_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
